[rtl/mpq_pkg.sv]
`timescale 1ns / 1ps
// Package for the min priority queue: capacity, command and status codes,
// and the types passed between the queue cells. Used by every other file.
package mpq_pkg;

	// Number of keys the queue can hold.
	localparam int CAPACITY = 64;
	// Width of the internal entry counter, wide enough to hold CAPACITY itself.
	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam int KEY_W = 32;
	localparam int CMD_W = 2;
	localparam int STS_W = 2;
	localparam int CNT_OUT_W = 7;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

	localparam logic [STS_W-1:0] STS_OK = 2'd0;
	localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL = 2'd2;

	// Contents of one cell.
	typedef struct packed {
		logic valid;
		logic signed [KEY_W-1:0] key;
	} cell_state_t;

	// Operation broadcast to every cell in the same cycle.
	typedef struct packed {
		logic ins;
		logic del;
		logic signed [KEY_W-1:0] key;
	} cell_ctrl_t;

	// What a cell shows its right-hand neighbor.
	typedef struct packed {
		cell_state_t state;
		logic place;
	} cell_link_t;

endpackage

[rtl/mpq_req_if.sv]
`timescale 1ns / 1ps
// Request channel of the min priority queue: valid/ready with command and key.
// Depends on mpq_pkg.
interface mpq_req_if;
	logic valid;
	logic ready;
	logic [mpq_pkg::CMD_W-1:0] command;
	logic signed [mpq_pkg::KEY_W-1:0] key;

	modport source (output valid, output command, output key, input ready);
	modport sink (input valid, input command, input key, output ready);
endinterface

[rtl/mpq_rsp_if.sv]
`timescale 1ns / 1ps
// Response channel of the min priority queue: valid/ready with status,
// minimum and count. Depends on mpq_pkg.
interface mpq_rsp_if;
	logic valid;
	logic ready;
	logic [mpq_pkg::STS_W-1:0] status;
	logic signed [mpq_pkg::KEY_W-1:0] minimum;
	logic [mpq_pkg::CNT_OUT_W-1:0] count;

	modport source (output valid, output status, output minimum, output count, input ready);
	modport sink (input valid, input status, input minimum, input count, output ready);
endinterface

[rtl/mpq_cell.sv]
`timescale 1ns / 1ps
// One cell of the sorted chain: holds one key and its valid bit.
// Depends on mpq_pkg.
module mpq_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mpq_pkg::cell_ctrl_t  ctrl,
	input  mpq_pkg::cell_link_t  left,
	input  mpq_pkg::cell_state_t right,
	output mpq_pkg::cell_link_t  link
);

	logic valid_q;
	logic signed [mpq_pkg::KEY_W-1:0] key_q;
	mpq_pkg::cell_state_t state_cur;
	mpq_pkg::cell_state_t state_nxt;
	logic place;

	assign state_cur = {valid_q, key_q};

	// This cell lies at or behind the insert position: it is empty or holds a
	// key strictly greater than the new one, so equal keys stay in front.
	assign place = !valid_q || ($signed(key_q) > $signed(ctrl.key));

	// Insert shifts right from the insert position; delete shifts everything left.
	always_comb begin
		state_nxt = state_cur;
		if (ctrl.ins && place) begin
			if (left.place) begin
				state_nxt = left.state;
			end else begin
				state_nxt.valid = 1'b1;
				state_nxt.key = ctrl.key;
			end
		end else if (ctrl.del) begin
			state_nxt = right;
		end
	end

	// Valid bit is control state; the key needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= state_nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= state_nxt.key;
	end

	assign link.state = state_cur;
	assign link.place = place;

endmodule

[rtl/mpq_chain.sv]
`timescale 1ns / 1ps
// Row of CAPACITY sorted cells, linked to their neighbors.
// Depends on mpq_pkg and mpq_cell.
module mpq_chain (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mpq_pkg::cell_ctrl_t  ctrl,
	output mpq_pkg::cell_state_t head
);

	mpq_pkg::cell_link_t link [mpq_pkg::CAPACITY];
	mpq_pkg::cell_link_t left_in [mpq_pkg::CAPACITY];
	mpq_pkg::cell_state_t right_in [mpq_pkg::CAPACITY];

	// Wire each cell to its neighbors; the ends see an empty, non-placing cell.
	always_comb begin
		for (int i = 0; i < mpq_pkg::CAPACITY; i++) begin
			if (i == 0) begin
				left_in[i] = '0;
			end else begin
				left_in[i] = link[i-1];
			end
			if (i == mpq_pkg::CAPACITY - 1) begin
				right_in[i] = '0;
			end else begin
				right_in[i] = link[i+1].state;
			end
		end
	end

	for (genvar g = 0; g < mpq_pkg::CAPACITY; g++) begin : g_cell
		mpq_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.left   (left_in[g]),
			.right  (right_in[g]),
			.link   (link[g])
		);
	end

	assign head = link[0].state;

endmodule

[rtl/min_priority_queue_core.sv]
`timescale 1ns / 1ps
// Top level of the min priority queue: request decode, counter, response register.
// Depends on mpq_pkg, mpq_req_if, mpq_rsp_if and mpq_chain.
//
// Bounded min priority queue of signed 32-bit keys held in a chain of
// CAPACITY cells kept in ascending order. Each request is an insert, a
// delete-minimum or a peek, and produces one response with a status, the
// smallest key after the request (zero when empty) and the entry count.
// All cells compare the new key in parallel and shift one place toward a
// neighbor, so a request is accepted in every cycle while responses are
// taken, and the response appears the cycle after acceptance. Deleting or
// peeking on an empty queue reports empty and changes nothing; inserting
// into a full queue is dropped and reports full.
// Equal keys are all kept, a new key behind those equal to it.
module min_priority_queue_core (
	input logic clk,
	input logic arst_n,
	mpq_req_if.sink req,
	mpq_rsp_if.source rsp
);

	logic accept;
	logic full;
	logic empty;
	mpq_pkg::cell_ctrl_t ctrl;
	mpq_pkg::cell_state_t head;
	logic [mpq_pkg::CNT_W-1:0] count_q;
	logic [mpq_pkg::CNT_W-1:0] count_nxt;
	logic [mpq_pkg::STS_W-1:0] status_nxt;
	logic [mpq_pkg::STS_W-1:0] status_q;
	logic rsp_valid_q;
	logic [mpq_pkg::CNT_W+mpq_pkg::CNT_OUT_W-1:0] count_ext;

	// A new request enters only when the previous response leaves, so the
	// response fields can read the live cell and counter state directly.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept = req.valid && req.ready;

	assign full = (count_q == mpq_pkg::CNT_W'(mpq_pkg::CAPACITY));
	assign empty = (count_q == '0);

	// Decode the request into a cell operation, status and new count.
	always_comb begin
		ctrl.ins = 1'b0;
		ctrl.del = 1'b0;
		ctrl.key = req.key;
		status_nxt = mpq_pkg::STS_OK;
		count_nxt = count_q;
		case (req.command)
			mpq_pkg::CMD_INSERT: begin
				if (full) begin
					status_nxt = mpq_pkg::STS_FULL;
				end else begin
					ctrl.ins = accept;
					count_nxt = count_q + 1'b1;
				end
			end
			mpq_pkg::CMD_DELETE: begin
				if (empty) begin
					status_nxt = mpq_pkg::STS_EMPTY;
				end else begin
					ctrl.del = accept;
					count_nxt = count_q - 1'b1;
				end
			end
			default: begin
				if (empty) begin
					status_nxt = mpq_pkg::STS_EMPTY;
				end
			end
		endcase
	end

	mpq_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.head   (head)
	);

	// Counter, response status and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_nxt;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_nxt;
		end
	end

	// Response fields; the count is fitted to the seven-bit field.
	assign count_ext = {{mpq_pkg::CNT_OUT_W{1'b0}}, count_q};
	assign rsp.valid = rsp_valid_q;
	assign rsp.status = status_q;
	assign rsp.minimum = head.valid ? head.key : '0;
	assign rsp.count = count_ext[mpq_pkg::CNT_OUT_W-1:0];

endmodule
